FILE: rtl/core/ftpm_pkg.sv
package ftpm_pkg;

  localparam int unsigned SAMPLE_DEPTH = 1024;
  localparam int unsigned ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned TS_W = 63;
  localparam int unsigned SMP_W = 32;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_END    = 3'd1,
    OP_SWAP   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_REPORT = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_NEXT,
    ST_PICK,
    ST_SET_DONE,
    ST_REPORT,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/frame_time_percentile_monitor.sv
// Channel  | Direction       | Signals
// ---------+-----------------+------------------------------------------------
// request  | in (busy out)   | start, busy, opcode, timestamp_ns
// result   | out             | strobe, result_kind, frame_index, frame_count,
//          |                 | work_median_ns, work_p95_ns, work_worst_ns,
//          |                 | interval_median_ns, interval_p95_ns, overflow
//
// Begin, swap, clear and unused requests leave busy low.
// A frame end stores its sample (if the store has room) at the accept edge, holds busy
// for one cycle and strobes its notice in the cycle after that.
// A report finds ranks with a shared pair of comparators (v has rank r if
// count(<v) <= r < count(<=v)); busy covers both sets and the emit state,
// then the report strobes.
// Reset (rst, synchronous) clears the counts; no clearing pass. No output stall.
module frame_time_percentile_monitor
  import ftpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               opcode,
  input  logic [ftpm_pkg::TS_W-1:0] timestamp_ns,
  output logic                     strobe,
  output logic                     result_kind,
  output logic [9:0]               frame_index,
  output logic [10:0]              frame_count,
  output logic [31:0]              work_median_ns,
  output logic [31:0]              work_p95_ns,
  output logic [31:0]              work_worst_ns,
  output logic [31:0]              interval_median_ns,
  output logic [31:0]              interval_p95_ns,
  output logic                     overflow
);

  // sample stores
  logic [SMP_W-1:0] work_mem [SAMPLE_DEPTH];
  logic [SMP_W-1:0] ival_mem [SAMPLE_DEPTH];

  logic [TS_W-1:0]  frame_start_time;
  logic [TS_W-1:0]  last_swap_time;
  logic             last_swap_valid;
  logic [CNT_W-1:0] work_count;
  logic [CNT_W-1:0] interval_count;
  logic             dropped_flag;

  state_t state, state_next;

  // search registers
  logic             set_sel;      // 0 work, 1 interval
  logic [CNT_W-1:0] n_cur;
  logic [ADDR_W-1:0] cand_idx;   // candidate index
  logic [ADDR_W-1:0] scan_idx;
  logic [SMP_W-1:0] cand_val;
  logic [SMP_W-1:0] rd_data;
  logic [CNT_W-1:0] cnt_lt;
  logic [CNT_W-1:0] cnt_le;
  logic [CNT_W-1:0] rank_med;
  logic [CNT_W-1:0] rank_p95;
  logic [SMP_W-1:0] res_med, res_p95, res_max;
  logic             got_med, got_p95;
  logic             have_max;
  logic             end_pending;
  logic             cand_phase;

  logic accept;
  assign accept = start && !busy;

  function automatic logic [SMP_W-1:0] span_ns(input logic [TS_W-1:0] from,
                                               input logic [TS_W-1:0] to);
    logic [TS_W-1:0] d;
    d = to - from;
    if (to < from) return '0;
    if (|d[TS_W-1:SMP_W]) return '1;
    return d[SMP_W-1:0];
  endfunction

  // ranks: (n+1)/2-1 and ceil(95n/100)-1 = n - floor(n/20) - 1;
  // floor(n/20) = floor((n/4) * 52429 / 2^18), exact for these counts
  logic [CNT_W+13:0] n_div20_prod;
  logic [CNT_W-1:0] n_sel;
  assign n_sel = set_sel ? interval_count : work_count;
  assign n_div20_prod = (CNT_W+14)'(n_sel[CNT_W-1:2]) * (CNT_W+14)'(52429);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept && opcode == OP_REPORT) state_next = ST_SETUP;
      ST_SETUP:     state_next = (n_sel == '0) ? ST_SET_DONE : ST_SCAN_RD;
      ST_SCAN_RD:   state_next = ST_SCAN_CMP;
      ST_SCAN_CMP:  state_next = cand_phase ? ST_SCAN_RD : ST_SCAN_NEXT;
      ST_SCAN_NEXT: state_next = (CNT_W'(scan_idx) == n_cur - 1'b1) ? ST_PICK
                                                                    : ST_SCAN_RD;
      ST_PICK:      state_next = ((got_med || (cnt_lt <= rank_med && rank_med < cnt_le))
                                  && (got_p95 || (cnt_lt <= rank_p95 && rank_p95 < cnt_le))
                                  && CNT_W'(cand_idx) == n_cur - 1'b1)
                                 || CNT_W'(cand_idx) == n_cur - 1'b1
                                 ? ST_SET_DONE : ST_SCAN_RD;
      ST_SET_DONE:  state_next = set_sel ? ST_EMIT : ST_SETUP;
      ST_EMIT:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE) || end_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame_start_time <= '0;
      last_swap_time <= '0;
      last_swap_valid <= 1'b0;
      work_count <= '0;
      interval_count <= '0;
      dropped_flag <= 1'b0;
      end_pending <= 1'b0;
      strobe <= 1'b0;
      set_sel <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= end_pending || (state == ST_EMIT);
      end_pending <= accept && opcode == OP_END;
      if (end_pending) begin
        result_kind <= 1'b0;
        frame_index <= 10'(work_count - 1'b1);
        frame_count <= 11'(work_count);
        work_median_ns <= '0;
        work_p95_ns <= '0;
        work_worst_ns <= '0;
        interval_median_ns <= '0;
        interval_p95_ns <= '0;
        overflow <= dropped_flag;
      end
      if (accept) begin
        case (opcode)
          OP_BEGIN: frame_start_time <= timestamp_ns;
          OP_END: begin
            if (work_count < CNT_W'(SAMPLE_DEPTH)) begin
              work_count <= work_count + 1'b1;
            end else begin
              dropped_flag <= 1'b1;
            end
          end
          OP_SWAP: begin
            if (last_swap_valid) begin
              if (interval_count < CNT_W'(SAMPLE_DEPTH)) begin
                interval_count <= interval_count + 1'b1;
              end else begin
                dropped_flag <= 1'b1;
              end
            end
            last_swap_time <= timestamp_ns;
            last_swap_valid <= 1'b1;
          end
          OP_CLEAR: begin
            work_count <= '0;
            interval_count <= '0;
            last_swap_valid <= 1'b0;
            dropped_flag <= 1'b0;
          end
          OP_REPORT: set_sel <= 1'b0;
          default: ;
        endcase
      end
      if (state == ST_SET_DONE) begin
        set_sel <= 1'b1;
        if (!set_sel) begin
          work_median_ns <= res_med;
          work_p95_ns <= res_p95;
          work_worst_ns <= res_max;
        end else begin
          interval_median_ns <= res_med;
          interval_p95_ns <= res_p95;
        end
      end
      if (state == ST_EMIT) begin
        result_kind <= 1'b1;
        frame_index <= '0;
        frame_count <= 11'(work_count);
        overflow <= dropped_flag;
      end
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_END && work_count < CNT_W'(SAMPLE_DEPTH)) begin
      work_mem[work_count[ADDR_W-1:0]] <= span_ns(frame_start_time, timestamp_ns);
    end
    if (accept && opcode == OP_SWAP && last_swap_valid
        && interval_count < CNT_W'(SAMPLE_DEPTH)) begin
      ival_mem[interval_count[ADDR_W-1:0]] <= span_ns(last_swap_time, timestamp_ns);
    end
  end

  // registered store read: candidate fetch, then scan reads
  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = cand_phase ? cand_idx : scan_idx;
  always_ff @(posedge clk) begin
    rd_data <= set_sel ? ival_mem[rd_addr] : work_mem[rd_addr];
  end

  // rank search: each candidate is fetched once, then the set is scanned
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_phase <= 1'b0;
    end else begin
      case (state)
        ST_SETUP: begin
          n_cur <= n_sel;
          rank_med <= CNT_W'((n_sel + 1'b1) >> 1) - 1'b1;
          rank_p95 <= n_sel - CNT_W'(n_div20_prod[CNT_W+13:18]) - 1'b1;
          cand_idx <= '0;
          scan_idx <= '0;
          cnt_lt <= '0;
          cnt_le <= '0;
          got_med <= 1'b0;
          got_p95 <= 1'b0;
          have_max <= 1'b0;
          res_med <= '0;
          res_p95 <= '0;
          res_max <= '0;
          cand_phase <= 1'b1;
        end
        ST_SCAN_CMP: begin
          if (cand_phase) begin
            cand_val <= rd_data;
            cand_phase <= 1'b0;
          end else begin
            if (rd_data < cand_val) cnt_lt <= cnt_lt + 1'b1;
            if (rd_data <= cand_val) cnt_le <= cnt_le + 1'b1;
          end
        end
        ST_SCAN_NEXT: begin
          if (!(CNT_W'(scan_idx) == n_cur - 1'b1)) scan_idx <= scan_idx + 1'b1;
        end
        ST_PICK: begin
          if (!got_med && cnt_lt <= rank_med && rank_med < cnt_le) begin
            res_med <= cand_val;
            got_med <= 1'b1;
          end
          if (!got_p95 && cnt_lt <= rank_p95 && rank_p95 < cnt_le) begin
            res_p95 <= cand_val;
            got_p95 <= 1'b1;
          end
          if (!have_max || cand_val > res_max) begin
            res_max <= cand_val;
            have_max <= 1'b1;
          end
          cand_idx <= cand_idx + 1'b1;
          scan_idx <= '0;
          cnt_lt <= '0;
          cnt_le <= '0;
          cand_phase <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_end_notice: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_END) |-> ##2 (strobe && !result_kind))
    else $error("frame end gave no notice");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    work_count <= CNT_W'(SAMPLE_DEPTH) && interval_count <= CNT_W'(SAMPLE_DEPTH))
    else $error("sample count past depth");
  a_busy_report: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_REPORT) |=> busy)
    else $error("report did not hold busy");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> strobe && result_kind)
    else $error("report strobe missing");
`endif

endmodule

FILE: verif/frame_time_percentile_monitor_test.sv
`timescale 1ns / 100ps

module frame_time_percentile_monitor_test;
  import ftpm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam logic [62:0] TS_MAX = {63{1'b1}};

  typedef struct packed {
    logic        kind;
    logic [9:0]  index;
    logic [10:0] count;
    logic [31:0] work_med;
    logic [31:0] work_p95;
    logic [31:0] work_worst;
    logic [31:0] intv_med;
    logic [31:0] intv_p95;
    logic        ovf;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  opcode;
  logic [62:0] timestamp_ns;
  logic        strobe;
  logic        result_kind;
  logic [9:0]  frame_index;
  logic [10:0] frame_count;
  logic [31:0] work_median_ns;
  logic [31:0] work_p95_ns;
  logic [31:0] work_worst_ns;
  logic [31:0] interval_median_ns;
  logic [31:0] interval_p95_ns;
  logic        overflow;

  // predictor state
  logic [62:0] frame_begin_ts;
  logic [62:0] prev_swap_ts;
  logic        prev_swap_seen;
  logic [31:0] work_times[$];
  logic [31:0] swap_intervals[$];
  logic        samples_dropped;

  frame_result_t pending_results[$];
  logic [62:0]   event_clock;
  int unsigned   cycle_count;
  int unsigned   error_count;

  frame_time_percentile_monitor dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .timestamp_ns(timestamp_ns),
    .strobe(strobe),
    .result_kind(result_kind),
    .frame_index(frame_index),
    .frame_count(frame_count),
    .work_median_ns(work_median_ns),
    .work_p95_ns(work_p95_ns),
    .work_worst_ns(work_worst_ns),
    .interval_median_ns(interval_median_ns),
    .interval_p95_ns(interval_p95_ns),
    .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Duration between two stamps: backwards gives 0, saturates at 32 bits.
  function automatic logic [31:0] span_ns(input logic [62:0] from_ts, input logic [62:0] to_ts);
    logic [62:0] d;
    if (to_ts < from_ts) return 32'd0;
    d = to_ts - from_ts;
    return (d > 63'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // Nearest-rank median, 95th percentile and maximum of a sample set.
  task automatic rank_stats(input logic [31:0] samples[$], output logic [31:0] med,
                            output logic [31:0] p95, output logic [31:0] worst);
    logic [31:0] sorted[$];
    int n;
    sorted = samples;
    n = sorted.size();
    if (n == 0) begin
      med = '0;
      p95 = '0;
      worst = '0;
    end else begin
      sorted.sort();
      med = sorted[(n + 1) / 2 - 1];
      p95 = sorted[(n * 95 + 99) / 100 - 1];
      worst = sorted[n - 1];
    end
  endtask

  // Updates the predicted monitor state for one accepted request and
  // queues the result it should produce.
  task automatic frame_stats_update(input logic [2:0] op, input logic [62:0] ts);
    frame_result_t r;
    logic [31:0] unused_worst;
    r = '0;
    case (op)
      OP_BEGIN: frame_begin_ts = ts;
      OP_END: begin
        if (work_times.size() < SAMPLE_DEPTH)
          work_times = {work_times, span_ns(frame_begin_ts, ts)};
        else samples_dropped = 1'b1;
        r.index = 10'(work_times.size() - 1);
        r.count = 11'(work_times.size());
        r.ovf = samples_dropped;
        pending_results = {pending_results, r};
      end
      OP_SWAP: begin
        if (prev_swap_seen) begin
          if (swap_intervals.size() < SAMPLE_DEPTH)
            swap_intervals = {swap_intervals, span_ns(prev_swap_ts, ts)};
          else samples_dropped = 1'b1;
        end
        prev_swap_ts = ts;
        prev_swap_seen = 1'b1;
      end
      OP_CLEAR: begin
        work_times.delete();
        swap_intervals.delete();
        prev_swap_seen = 1'b0;
        samples_dropped = 1'b0;
      end
      OP_REPORT: begin
        r.kind = 1'b1;
        r.count = 11'(work_times.size());
        rank_stats(work_times, r.work_med, r.work_p95, r.work_worst);
        rank_stats(swap_intervals, r.intv_med, r.intv_p95, unused_worst);
        r.ovf = samples_dropped;
        pending_results = {pending_results, r};
      end
      default: ;  // unused opcodes are ignored
    endcase
  endtask

  // Random idle stretch: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge after the request is taken.
  task automatic send_request(input logic [2:0] op, input logic [62:0] ts);
    int unsigned gap;
    start <= 1'b1;
    opcode <= op;
    timestamp_ns <= ts;
    do @(posedge clk); while (busy);
    frame_stats_update(op, ts);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      opcode <= 3'($urandom);
      timestamp_ns <= 63'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
  endtask

  // Plausible event time: mostly forward steps, sometimes backwards or far jumps.
  function automatic logic [62:0] next_stamp();
    int unsigned roll;
    roll = $urandom_range(0, 39);
    if (roll == 0) return 63'({$urandom, $urandom});
    if (roll == 1) return event_clock - 63'($urandom_range(1, 100000));
    if (roll == 2)
      event_clock = event_clock + {28'd0, 3'($urandom_range(1, 7)), 32'($urandom)};
    else event_clock = event_clock + 63'($urandom_range(1, 40000));
    return event_clock;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, result_kind);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.kind, result_kind);
        check_field("frame_index", e.index, frame_index);
        check_field("frame_count", e.count, frame_count);
        check_field("work_median_ns", e.work_med, work_median_ns);
        check_field("work_p95_ns", e.work_p95, work_p95_ns);
        check_field("work_worst_ns", e.work_worst, work_worst_ns);
        check_field("interval_median_ns", e.intv_med, interval_median_ns);
        check_field("interval_p95_ns", e.intv_p95, interval_p95_ns);
        check_field("overflow", e.ovf, overflow);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Field extremes, empty sets, backwards time, saturation, first swap,
  // unused opcodes and clear.
  task automatic test_directed_events();
    send_request(OP_REPORT, '0);
    send_request(OP_BEGIN, '0);
    send_request(OP_END, TS_MAX);
    send_request(OP_BEGIN, TS_MAX);
    send_request(OP_END, '0);
    send_request(OP_BEGIN, 63'd1000);
    send_request(OP_END, 63'd1000);
    send_request(OP_END, 63'd1000 + 63'hFFFF_FFFF);
    send_request(OP_SWAP, 63'd5000);
    send_request(OP_REPORT, 63'd5000);
    send_request(OP_SWAP, 63'd21667);
    send_request(OP_SWAP, 63'd100);
    send_request(OP_SWAP, TS_MAX);
    send_request(3'd5, TS_MAX);
    send_request(3'd6, '0);
    send_request(3'd7, {32'($urandom), 31'($urandom)});
    send_request(OP_REPORT, TS_MAX);
    send_request(OP_CLEAR, '0);
    send_request(OP_REPORT, '0);
    send_request(OP_SWAP, 63'd50);
    send_request(OP_END, 63'd77);
    send_request(OP_REPORT, 63'd90);
    send_request(OP_CLEAR, 63'd95);
  endtask

  // Mostly well-formed begin/end/swap frames with random timing, with
  // occasional reports on small sets, clears and stray requests.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned roll;
    logic [62:0] t0;
    sent = 0;
    while (sent < 525) begin
      roll = $urandom_range(0, 99);
      if (work_times.size() > 40 || swap_intervals.size() > 40) begin
        send_request(OP_CLEAR, next_stamp());
        sent++;
      end else if (roll < 70) begin
        t0 = next_stamp();
        send_request(OP_BEGIN, t0);
        send_request(OP_END, next_stamp());
        send_request(OP_SWAP, next_stamp());
        sent += 3;
      end else if (roll < 82) begin
        send_request(OP_REPORT, next_stamp());
        sent++;
      end else if (roll < 85) begin
        send_request(OP_CLEAR, next_stamp());
        sent++;
      end else begin
        send_request(3'($urandom_range(0, 7)), next_stamp());
        sent++;
      end
    end
    send_request(OP_REPORT, next_stamp());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    timestamp_ns = '0;
    cycle_count = 0;
    error_count = 0;
    event_clock = 63'd1000;
    frame_begin_ts = '0;
    prev_swap_ts = '0;
    prev_swap_seen = 1'b0;
    samples_dropped = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_events();
    test_random_frames();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
